/* hw/rtl/fsgu_pkg.sv */
// ----------------------------------------------------------------------------
// fsgu_pkg
// Shared types and constants for the falling sand grid update block.
// ----------------------------------------------------------------------------
package fsgu_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 64;
  localparam int unsigned GRID_HEIGHT_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned CELL_W   = 8;

  localparam logic [CELL_W-1:0] AIR_RESET  = 8'd0;
  localparam logic [CELL_W-1:0] SAND_RESET = 8'd1;

  // configuration register indexes
  localparam logic CFG_AIR  = 1'b0;
  localparam logic CFG_SAND = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PASS  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_PASS
  } op_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [CELL_W-1:0]   cell_value;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_value;
    logic              pass_done;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic               on_grid;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [CELL_W-1:0]  cell_value;
  } cmd_t;

  // queue status seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_stat_t;

endpackage

/* hw/rtl/fsgu_front.sv */
// ----------------------------------------------------------------------------
// fsgu_front
// Accepts input items, decodes the action and checks the coordinate range.
// ----------------------------------------------------------------------------
module fsgu_front #(
  parameter int unsigned GRID_WIDTH  = fsgu_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = fsgu_pkg::GRID_HEIGHT_DEF
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fsgu_pkg::in_item_t in_data_i,
  input  logic              full_i,
  input  logic              clearing_i,
  output logic              push_o,
  output fsgu_pkg::cmd_t    cmd_o
);

  // hold off while the grid is being cleared or the queue has no room
  assign in_stall_o = full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.cell_x     = in_data_i.cell_x;
    cmd_o.cell_y     = in_data_i.cell_y;
    cmd_o.cell_value = in_data_i.cell_value;
    cmd_o.on_grid    = (32'(in_data_i.cell_x) < GRID_WIDTH) &&
                       (32'(in_data_i.cell_y) < GRID_HEIGHT);
    case (in_data_i.action)
      fsgu_pkg::ACT_WRITE: cmd_o.op = fsgu_pkg::OP_WRITE;
      fsgu_pkg::ACT_READ:  cmd_o.op = fsgu_pkg::OP_READ;
      fsgu_pkg::ACT_PASS:  cmd_o.op = fsgu_pkg::OP_PASS;
      default:             cmd_o.op = fsgu_pkg::OP_NONE;
    endcase
  end

endmodule

/* hw/rtl/fsgu_fifo.sv */
// ----------------------------------------------------------------------------
// fsgu_fifo
// Short command queue between the front end and the grid engine.
// ----------------------------------------------------------------------------
module fsgu_fifo #(
  parameter int unsigned DEPTH = fsgu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fsgu_pkg::cmd_t    push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output fsgu_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  fsgu_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]  cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o        = (cnt_q == NW'(DEPTH));
  assign stat_o.empty  = (cnt_q == '0);
  assign stat_o.head   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/fsgu_engine.sv */
// ----------------------------------------------------------------------------
// fsgu_engine
// Grid memory with clearing sweep, cell access and the in-place update pass.
// ----------------------------------------------------------------------------
module fsgu_engine #(
  parameter int unsigned GRID_WIDTH  = fsgu_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = fsgu_pkg::GRID_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [fsgu_pkg::CELL_W-1:0]     air_code_i,
  input  logic [fsgu_pkg::CELL_W-1:0]     sand_code_i,
  input  fsgu_pkg::q_stat_t               q_i,
  output logic                            pop_o,
  output logic                            clearing_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fsgu_pkg::out_item_t             out_data_o
);

  localparam int unsigned DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(GRID_WIDTH);
  localparam int unsigned RW    = $clog2(GRID_HEIGHT);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_HERE,
    S_CHK,
    S_DOWN,
    S_WEST,
    S_EAST,
    S_CLR
  } state_e;

  state_e                      state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [CW-1:0]               col_q, col_d;
  logic [RW-1:0]               row_q, row_d;
  logic                        out_valid_q;
  fsgu_pkg::out_item_t         out_data_q, out_data_d;
  logic                        out_load;
  logic [fsgu_pkg::CELL_W-1:0] mem [DEPTH];
  logic [fsgu_pkg::CELL_W-1:0] rdata_q;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_addr;
  logic [fsgu_pkg::CELL_W-1:0] mem_wdata;

  logic                        out_free, adv, last_cell, rd_air;
  logic [CW-1:0]               nxt_col;
  logic [RW-1:0]               nxt_row;
  logic [AW-1:0]               here_addr, below_addr, west_addr, east_addr, item_addr;
  logic [AW-1:0]               nxt_addr;

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] col,
                                               input logic [31:0] row);
    logic [31:0] lin;
    lin = row * GRID_WIDTH + col;
    return lin[AW-1:0];
  endfunction

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign rd_air     = (rdata_q == air_code_i);
  assign last_cell  = (row_q == '0) && (col_q == CW'(GRID_WIDTH - 1));

  // visit order: bottom to top within a column, then the next column
  always_comb begin
    if (row_q == '0) begin
      nxt_col = col_q + 1'b1;
      nxt_row = RW'(GRID_HEIGHT - 1);
    end else begin
      nxt_col = col_q;
      nxt_row = row_q - 1'b1;
    end
  end

  assign here_addr  = cell_addr(32'(col_q), 32'(row_q));
  assign below_addr = cell_addr(32'(col_q), 32'(row_q) + 32'd1);
  assign west_addr  = cell_addr(32'(col_q) - 32'd1, 32'(row_q));
  assign east_addr  = cell_addr(32'(col_q) + 32'd1, 32'(row_q));
  assign nxt_addr   = cell_addr(32'(nxt_col), 32'(nxt_row));
  assign item_addr  = cell_addr(32'(q_i.head.cell_x), 32'(q_i.head.cell_y));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    col_d      = col_q;
    row_d      = row_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = here_addr;
    mem_wdata  = air_code_i;
    pop_o      = 1'b0;
    out_load   = 1'b0;
    out_data_d = '0;
    adv        = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = fsgu_pkg::AIR_RESET;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_i.empty && out_free) begin
          pop_o = 1'b1;
          case (q_i.head.op)
            fsgu_pkg::OP_WRITE: begin
              mem_we    = q_i.head.on_grid;
              mem_addr  = item_addr;
              mem_wdata = q_i.head.cell_value;
              out_load  = 1'b1;
            end
            fsgu_pkg::OP_READ: begin
              if (q_i.head.on_grid) begin
                mem_re   = 1'b1;
                mem_addr = item_addr;
                state_d  = S_RDWAIT;
              end else begin
                // off-grid cells read as empty
                out_load              = 1'b1;
                out_data_d.read_value = air_code_i;
              end
            end
            fsgu_pkg::OP_PASS: begin
              col_d   = '0;
              row_d   = RW'(GRID_HEIGHT - 1);
              state_d = S_HERE;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        out_load              = 1'b1;
        out_data_d.read_value = rdata_q;
        state_d               = S_IDLE;
      end
      S_HERE: begin
        mem_re  = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!rd_air && (rdata_q == sand_code_i) && (row_q != RW'(GRID_HEIGHT - 1))) begin
          mem_re   = 1'b1;
          mem_addr = below_addr;
          state_d  = S_DOWN;
        end else begin
          adv = 1'b1;
        end
      end
      S_DOWN: begin
        if (rd_air) begin
          mem_we    = 1'b1;
          mem_addr  = below_addr;
          mem_wdata = sand_code_i;
          state_d   = S_CLR;
        end else if (col_q != '0) begin
          mem_re   = 1'b1;
          mem_addr = west_addr;
          state_d  = S_WEST;
        end else if (col_q != CW'(GRID_WIDTH - 1)) begin
          mem_re   = 1'b1;
          mem_addr = east_addr;
          state_d  = S_EAST;
        end else begin
          adv = 1'b1;
        end
      end
      S_WEST: begin
        if (rd_air) begin
          mem_we    = 1'b1;
          mem_addr  = west_addr;
          mem_wdata = sand_code_i;
          state_d   = S_CLR;
        end else if (col_q != CW'(GRID_WIDTH - 1)) begin
          mem_re   = 1'b1;
          mem_addr = east_addr;
          state_d  = S_EAST;
        end else begin
          adv = 1'b1;
        end
      end
      S_EAST: begin
        if (rd_air) begin
          mem_we    = 1'b1;
          mem_addr  = east_addr;
          mem_wdata = sand_code_i;
          state_d   = S_CLR;
        end else begin
          adv = 1'b1;
        end
      end
      S_CLR: begin
        // moved sand leaves air behind
        mem_we    = 1'b1;
        mem_addr  = here_addr;
        mem_wdata = air_code_i;
        adv       = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (adv) begin
      if (last_cell) begin
        out_load             = 1'b1;
        out_data_d.pass_done = 1'b1;
        state_d              = S_IDLE;
      end else begin
        col_d = nxt_col;
        row_d = nxt_row;
        if (!mem_we) begin
          // port is free, fetch the next cell right away
          mem_re   = 1'b1;
          mem_addr = nxt_addr;
          state_d  = S_CHK;
        end else begin
          state_d = S_HERE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // no command leaves the queue during the clearing sweep
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("command popped during clearing sweep");

  // single memory port
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // the cell check always sees freshly read data
  a_chk_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> $past(mem_re))
    else $error("cell check without a preceding read");

endmodule

/* hw/rtl/falling_sand_grid_update.sv */
// Write and no-op items pass through the queue and the result register; on-grid reads
// also the grid read register. Update pass on the single grid port: air, other and
// bottom-row cells need one read; other sand cells read below, west, east as needed.
// Items run one at a time in the engine; a small queue takes new items meanwhile.
// After reset the grid is swept to zero while input stays stalled.
// Configuration registers reset to air 0 and sand 1 and are always ready.
// ----------------------------------------------------------------------------
// falling_sand_grid_update
// Grid of cell ids with write, read and an in-place falling sand update pass.
// ----------------------------------------------------------------------------
module falling_sand_grid_update #(
  parameter int unsigned GRID_WIDTH  = fsgu_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = fsgu_pkg::GRID_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH = fsgu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fsgu_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fsgu_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [fsgu_pkg::CELL_W-1:0] cfg_data_i
);

  logic [fsgu_pkg::CELL_W-1:0] air_q, sand_q;
  logic                        push, pop, full, clearing;
  fsgu_pkg::cmd_t              cmd;
  fsgu_pkg::q_stat_t           q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_q  <= fsgu_pkg::AIR_RESET;
      sand_q <= fsgu_pkg::SAND_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fsgu_pkg::CFG_AIR:  air_q  <= cfg_data_i;
        fsgu_pkg::CFG_SAND: sand_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fsgu_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .clearing_i (clearing),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  fsgu_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(cmd),
    .pop_i      (pop),
    .full_o     (full),
    .stat_o     (q_stat)
  );

  fsgu_engine #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .air_code_i (air_q),
    .sand_code_i(sand_q),
    .q_i        (q_stat),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for falling_sand_grid_update. Writes, reads, update passes
// and no-op items go in under random idling and stalls. A local grid copy
// predicts every result. Air and sand codes are switched between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int GW = fsgu_pkg::GRID_WIDTH_DEF;
  localparam int GH = fsgu_pkg::GRID_HEIGHT_DEF;
  localparam int AW = fsgu_pkg::ACTION_W;
  localparam int XW = fsgu_pkg::COORD_W;
  localparam int VW = fsgu_pkg::CELL_W;
  // unused action code, the block must answer it with an all-zero result
  localparam logic [AW-1:0] ACT_NOP = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  fsgu_pkg::in_item_t  in_data     = '0;
  logic                out_valid_o;
  logic                out_stall   = 1'b0;
  fsgu_pkg::out_item_t out_data_o;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index   = fsgu_pkg::CFG_AIR;
  logic [VW-1:0]       cfg_data    = '0;

  // local copy of the block state
  logic [VW-1:0]       cell_ids [GW*GH];
  logic [VW-1:0]       air_id  = fsgu_pkg::AIR_RESET;
  logic [VW-1:0]       sand_id = fsgu_pkg::SAND_RESET;

  fsgu_pkg::in_item_t  ops_pending [$];
  fsgu_pkg::out_item_t due_results [$];
  fsgu_pkg::out_item_t want;
  int                  mismatch_count = 0;
  int                  idle_pct = 11;
  int                  stall_pct = 11;

  falling_sand_grid_update DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // applies one item to the local grid and returns the result it must produce
  function automatic fsgu_pkg::out_item_t model_cell_op(fsgu_pkg::in_item_t it);
    fsgu_pkg::out_item_t res;
    int src;
    logic in_grid;
    res = '0;
    in_grid = (int'(it.cell_x) < GW) && (int'(it.cell_y) < GH);
    case (it.action)
      fsgu_pkg::ACT_WRITE: begin
        if (in_grid) cell_ids[int'(it.cell_x) + int'(it.cell_y) * GW] = it.cell_value;
      end
      fsgu_pkg::ACT_READ: begin
        res.read_value = in_grid ? cell_ids[int'(it.cell_x) + int'(it.cell_y) * GW] : air_id;
      end
      fsgu_pkg::ACT_PASS: begin
        // columns left to right, rows bottom to top, grid updated in place
        for (int col = 0; col < GW; col++) begin
          for (int row = GH - 1; row >= 0; row--) begin
            src = col + row * GW;
            if (cell_ids[src] == air_id || cell_ids[src] != sand_id || row + 1 >= GH) continue;
            if (cell_ids[src + GW] == air_id) begin
              cell_ids[src + GW] = cell_ids[src];
              cell_ids[src] = air_id;
            end else if (col > 0 && cell_ids[src - 1] == air_id) begin
              cell_ids[src - 1] = cell_ids[src];
              cell_ids[src] = air_id;
            end else if (col + 1 < GW && cell_ids[src + 1] == air_id) begin
              cell_ids[src + 1] = cell_ids[src];
              cell_ids[src] = air_id;
            end
          end
        end
        res.pass_done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // input driver, predicts at each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) due_results.push_back(model_cell_op(in_data));
      if (!in_valid || !in_stall_o) begin
        if (ops_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= ops_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (out_data_o.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      out_data_o.read_value, want.read_value));
          if (out_data_o.pass_done !== want.pass_done)
            report_mismatch($sformatf("pass_done %0b, expected %0b",
                                      out_data_o.pass_done, want.pass_done));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_op(logic [AW-1:0] act, logic [XW-1:0] x,
                         logic [XW-1:0] y, logic [VW-1:0] v);
    fsgu_pkg::in_item_t it;
    it.action     = act;
    it.cell_x     = x;
    it.cell_y     = y;
    it.cell_value = v;
    ops_pending.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [VW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == fsgu_pkg::CFG_AIR) air_id = val;
    else sand_id = val;
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (ops_pending.size() != 0 || in_valid || due_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // a few cells in a 4x4 patch, one update pass, then reads of the patch
  task automatic queue_sand_scene();
    int x0, y0, r;
    logic [VW-1:0] v;
    case ($urandom_range(3))
      0:       x0 = 0;
      1:       x0 = GW - 4;
      default: x0 = $urandom_range(GW - 4);
    endcase
    case ($urandom_range(3))
      0:       y0 = 0;
      1:       y0 = GH - 4;
      default: y0 = $urandom_range(GH - 4);
    endcase
    repeat ($urandom_range(4, 7)) begin
      r = $urandom_range(9);
      v = (r < 5) ? sand_id : (r < 8) ? air_id : VW'($urandom);
      push_op(fsgu_pkg::ACT_WRITE, XW'(x0 + $urandom_range(3)), XW'(y0 + $urandom_range(3)), v);
    end
    push_op(fsgu_pkg::ACT_PASS, XW'($urandom), XW'($urandom), VW'($urandom));
    repeat ($urandom_range(2, 4))
      push_op(fsgu_pkg::ACT_READ, XW'(x0 + $urandom_range(3)), XW'(y0 + $urandom_range(3)),
              VW'($urandom));
  endtask

  task automatic queue_noise(int n);
    repeat (n)
      push_op(AW'($urandom_range(3)), XW'($urandom), XW'($urandom), VW'($urandom));
  endtask

  initial begin
    logic [VW-1:0] code;
    foreach (cell_ids[i]) cell_ids[i] = fsgu_pkg::AIR_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(fsgu_pkg::CFG_AIR, 8'd0);
    write_reg(fsgu_pkg::CFG_SAND, 8'd1);
    // plain fall, bottom row, west at right edge, east at left edge then fall,
    // fully boxed in grain, extreme ids and coordinates, unused action
    push_op(fsgu_pkg::ACT_WRITE, 6'd0, 6'd0, 8'd1);
    push_op(fsgu_pkg::ACT_WRITE, 6'd63, 6'd63, 8'd1);
    push_op(fsgu_pkg::ACT_WRITE, 6'd63, 6'd62, 8'd1);
    push_op(fsgu_pkg::ACT_WRITE, 6'd0, 6'd10, 8'd1);
    push_op(fsgu_pkg::ACT_WRITE, 6'd0, 6'd11, 8'd200);
    push_op(fsgu_pkg::ACT_WRITE, 6'd5, 6'd20, 8'd1);
    push_op(fsgu_pkg::ACT_WRITE, 6'd5, 6'd21, 8'd9);
    push_op(fsgu_pkg::ACT_WRITE, 6'd4, 6'd20, 8'd9);
    push_op(fsgu_pkg::ACT_WRITE, 6'd6, 6'd20, 8'd9);
    push_op(fsgu_pkg::ACT_WRITE, 6'd63, 6'd0, 8'd255);
    push_op(fsgu_pkg::ACT_READ, 6'd63, 6'd0, 8'd0);
    push_op(ACT_NOP, 6'd63, 6'd63, 8'd255);
    push_op(fsgu_pkg::ACT_PASS, 6'd0, 6'd0, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd0, 6'd1, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd0, 6'd0, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd62, 6'd62, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd63, 6'd63, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd1, 6'd11, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd5, 6'd20, 8'd0);
    push_op(fsgu_pkg::ACT_PASS, 6'd0, 6'd0, 8'd0);
    push_op(fsgu_pkg::ACT_READ, 6'd0, 6'd2, 8'd0);
    wait_idle();

    // extreme codes: every reset cell now counts as sand
    write_reg(fsgu_pkg::CFG_AIR, 8'd255);
    write_reg(fsgu_pkg::CFG_SAND, 8'd0);
    repeat (2) queue_sand_scene();
    wait_idle();

    // swapped extremes, no idling on either side
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(fsgu_pkg::CFG_AIR, 8'd0);
    write_reg(fsgu_pkg::CFG_SAND, 8'd255);
    repeat (2) queue_sand_scene();
    wait_idle();
    idle_pct  = 11;
    stall_pct = 11;

    // air and sand share one code, nothing may move
    code = VW'($urandom);
    write_reg(fsgu_pkg::CFG_AIR, code);
    write_reg(fsgu_pkg::CFG_SAND, code);
    queue_sand_scene();
    queue_noise(5);
    wait_idle();

    write_reg(fsgu_pkg::CFG_AIR, VW'($urandom_range(1, 3)));
    do code = VW'($urandom); while (code == air_id);
    write_reg(fsgu_pkg::CFG_SAND, code);
    queue_sand_scene();
    queue_noise(5);
    wait_idle();
    queue_noise(5);
    queue_sand_scene();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(3_000_000 * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
